FILE: rtl/nge_pkg.sv
// ----------------------------------------------------------------------------
// nge_pkg
// shared constants and register codes for the noise gate with envelope hold
// ----------------------------------------------------------------------------
package nge_pkg;

	// default parameter values
	localparam int SAMPLE_BITS_DEF = 12;
	localparam int COEFF_BITS_DEF  = 16;

	// fixed field widths
	localparam int THRESH_BITS    = 12;
	localparam int CFG_DATA_BITS  = 16;
	localparam int CFG_INDEX_BITS = 2;
	localparam int ENV_BITS       = 16;
	localparam int HOLD_BITS      = 16;

	// gain levels in q1.15
	localparam logic [ENV_BITS-1:0] GAIN_ONE  = 16'h8000;
	localparam logic [ENV_BITS-1:0] GAIN_HALF = 16'h4000;

	localparam logic [HOLD_BITS-1:0] COUNT_MAX = 16'hFFFF;

	// register indexes
	localparam logic [CFG_INDEX_BITS-1:0] REG_THRESHOLD = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_ATTACK    = 2'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_RELEASE   = 2'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_HOLD      = 2'd3;

	// register reset values
	localparam logic [THRESH_BITS-1:0]   THRESH_RST  = 12'd64;
	localparam logic [CFG_DATA_BITS-1:0] ATTACK_RST  = 16'd62603;
	localparam logic [CFG_DATA_BITS-1:0] RELEASE_RST = 16'd65476;
	localparam logic [HOLD_BITS-1:0]     HOLD_RST    = 16'd480;

endpackage

FILE: rtl/nge_if.sv
// ----------------------------------------------------------------------------
// nge_if
// valid/ready channels: sample items in, result items out, register writes
// ----------------------------------------------------------------------------
interface nge_in_if #(
	parameter int SAMPLE_BITS = nge_pkg::SAMPLE_BITS_DEF
);
	logic                   valid;
	logic                   ready;
	logic [SAMPLE_BITS-1:0] sample;
	logic                   chunk_end;

	modport source (output valid, sample, chunk_end, input ready);
	modport sink   (input valid, sample, chunk_end, output ready);
endinterface

interface nge_out_if;
	logic                           valid;
	logic                           ready;
	logic [nge_pkg::ENV_BITS-1:0]   envelope;
	logic                           gate_closed;
	logic                           gate_update;

	modport source (output valid, envelope, gate_closed, gate_update, input ready);
	modport sink   (input valid, envelope, gate_closed, gate_update, output ready);
endinterface

interface nge_cfg_if;
	logic                                 valid;
	logic                                 ready;
	logic [nge_pkg::CFG_INDEX_BITS-1:0]   index;
	logic [nge_pkg::CFG_DATA_BITS-1:0]    data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/nge_cfg_regs.sv
// ----------------------------------------------------------------------------
// nge_cfg_regs
// configuration register file, always ready for a write
// ----------------------------------------------------------------------------
module nge_cfg_regs #(
	parameter int COEFF_BITS = nge_pkg::COEFF_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	nge_cfg_if.sink                            cfg,
	output logic [nge_pkg::THRESH_BITS-1:0]    threshold,
	output logic [COEFF_BITS-1:0]              attack_coeff,
	output logic [COEFF_BITS-1:0]              release_coeff,
	output logic [nge_pkg::HOLD_BITS-1:0]      hold_samples
);

	logic wr;

	assign cfg.ready = 1'b1;
	assign wr = cfg.valid & cfg.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold     <= nge_pkg::THRESH_RST;
			attack_coeff  <= COEFF_BITS'(nge_pkg::ATTACK_RST);
			release_coeff <= COEFF_BITS'(nge_pkg::RELEASE_RST);
			hold_samples  <= nge_pkg::HOLD_RST;
		end else if (wr) begin
			case (cfg.index)
				nge_pkg::REG_THRESHOLD: threshold     <= cfg.data[nge_pkg::THRESH_BITS-1:0];
				nge_pkg::REG_ATTACK:    attack_coeff  <= COEFF_BITS'(cfg.data);
				nge_pkg::REG_RELEASE:   release_coeff <= COEFF_BITS'(cfg.data);
				nge_pkg::REG_HOLD:      hold_samples  <= cfg.data[nge_pkg::HOLD_BITS-1:0];
				default: ;
			endcase
		end
	end

endmodule

FILE: rtl/nge_env_update.sv
// ----------------------------------------------------------------------------
// nge_env_update
// envelope and hold counter state with the combinational smoothing step
// ----------------------------------------------------------------------------
module nge_env_update #(
	parameter int SAMPLE_BITS = nge_pkg::SAMPLE_BITS_DEF,
	parameter int COEFF_BITS  = nge_pkg::COEFF_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               en,
	input  logic [SAMPLE_BITS-1:0]             sample,
	input  logic [nge_pkg::THRESH_BITS-1:0]    threshold,
	input  logic [COEFF_BITS-1:0]              attack_coeff,
	input  logic [COEFF_BITS-1:0]              release_coeff,
	input  logic [nge_pkg::HOLD_BITS-1:0]      hold_samples,
	output logic [nge_pkg::ENV_BITS-1:0]       env_next
);

	localparam int CMP_W = (SAMPLE_BITS > nge_pkg::THRESH_BITS) ? SAMPLE_BITS
	                                                              : nge_pkg::THRESH_BITS;
	localparam int ACC_W = COEFF_BITS + nge_pkg::ENV_BITS + 1;
	localparam int GAIN_SHIFT = nge_pkg::ENV_BITS - 1;
	localparam logic [SAMPLE_BITS-1:0] MID = SAMPLE_BITS'(1) << (SAMPLE_BITS - 1);
	localparam logic [COEFF_BITS:0]    ONE_C = (COEFF_BITS + 1)'(1) << COEFF_BITS;
	localparam logic [ACC_W-1:0]       ROUND = ACC_W'(1) << (COEFF_BITS - 1);

	logic [nge_pkg::ENV_BITS-1:0]  env_q;
	logic [nge_pkg::HOLD_BITS-1:0] hold_q;

	logic [SAMPLE_BITS-1:0]                   mag;
	logic                                     target_one;
	logic                                     rise;
	logic                                     decay;
	logic [COEFF_BITS-1:0]                    coeff;
	logic [COEFF_BITS:0]                      one_minus;
	logic [COEFF_BITS+nge_pkg::ENV_BITS-1:0]  prod;
	logic [ACC_W-1:0]                         acc;
	logic [nge_pkg::ENV_BITS:0]               smooth_raw;
	logic [nge_pkg::ENV_BITS-1:0]             smoothed;

	// distance from midpoint and gate target
	assign mag = sample[SAMPLE_BITS-1] ? (sample - MID) : (MID - sample);
	assign target_one = CMP_W'(mag) >= CMP_W'(threshold);

	// target above envelope only when target is one and envelope short of full scale
	assign rise  = target_one && (env_q < nge_pkg::GAIN_ONE);
	assign decay = !rise && (hold_q > hold_samples);

	// weighted mean of envelope and target, rounded half up
	assign coeff     = rise ? release_coeff : attack_coeff;
	assign one_minus = ONE_C - {1'b0, coeff};
	assign prod      = coeff * env_q;
	assign acc = ACC_W'(prod)
	           + (target_one ? (ACC_W'(one_minus) << GAIN_SHIFT) : '0)
	           + ROUND;
	assign smooth_raw = acc[ACC_W-1:COEFF_BITS];
	assign smoothed = (smooth_raw > {1'b0, nge_pkg::GAIN_ONE}) ? nge_pkg::GAIN_ONE
	                                                            : smooth_raw[nge_pkg::ENV_BITS-1:0];

	assign env_next = (rise || decay) ? smoothed : env_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			env_q  <= '0;
			hold_q <= '0;
		end else if (en) begin
			env_q <= env_next;
			if (rise) begin
				hold_q <= '0;
			end else if (!decay && (hold_q != nge_pkg::COUNT_MAX)) begin
				hold_q <= hold_q + 1'b1;
			end
		end
	end

	a_env_range: assert property (@(posedge clk) disable iff (!arst_n)
		env_q <= nge_pkg::GAIN_ONE)
		else $error("envelope above full scale");

	a_rise_clears: assert property (@(posedge clk) disable iff (!arst_n)
		en && rise |=> hold_q == '0)
		else $error("hold counter not cleared on rise");

	a_hold_count: assert property (@(posedge clk) disable iff (!arst_n)
		en && !rise && !decay && (hold_q != nge_pkg::COUNT_MAX)
		|=> hold_q == $past(hold_q) + 1'b1)
		else $error("hold counter did not advance");

endmodule

FILE: rtl/noise_gate_envelope_hold.sv
// ----------------------------------------------------------------------------
// noise_gate_envelope_hold
// Noise gate with hold. Each sample item is an offset-binary converter
// sample; its distance from midpoint is compared to the threshold register
// to give a target gain of one or zero. The q1.15 envelope rises toward a
// target above it with release_coeff and clears the hold counter; otherwise
// the counter counts up and, once past hold_samples, the envelope moves
// toward the target with attack_coeff. Every sample gives one result item
// with the envelope, gate_closed (envelope below one half) and gate_update
// (a copy of chunk_end). Throughput is one item per clock while results are
// taken; the envelope recurrence is one multiply-add. Samples pass the input
// register, then the result register, which lets a new sample enter while
// the previous result waits. The user must write registers only while the
// block is idle, not enforced by the block; the write port is always ready.
// ----------------------------------------------------------------------------
module noise_gate_envelope_hold #(
	parameter int SAMPLE_BITS = nge_pkg::SAMPLE_BITS_DEF,
	parameter int COEFF_BITS  = nge_pkg::COEFF_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	nge_in_if.sink     samples,
	nge_out_if.source  results,
	nge_cfg_if.sink    cfg
);

	// configuration
	logic [nge_pkg::THRESH_BITS-1:0] threshold;
	logic [COEFF_BITS-1:0]           attack_coeff;
	logic [COEFF_BITS-1:0]           release_coeff;
	logic [nge_pkg::HOLD_BITS-1:0]   hold_samples;

	// input register
	logic                   valid_s1;
	logic [SAMPLE_BITS-1:0] sample_s1;
	logic                   chunk_end_s1;

	// result register
	logic                         out_valid_q;
	logic [nge_pkg::ENV_BITS-1:0] envelope_q;
	logic                         gate_closed_q;
	logic                         gate_update_q;

	logic                         accept;
	logic                         adv;
	logic [nge_pkg::ENV_BITS-1:0] env_next;

	nge_cfg_regs #(
		.COEFF_BITS(COEFF_BITS)
	) u_cfg (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.threshold    (threshold),
		.attack_coeff (attack_coeff),
		.release_coeff(release_coeff),
		.hold_samples (hold_samples)
	);

	// the input stage moves on whenever the result register is empty or being drained
	assign adv           = valid_s1 && (!out_valid_q || results.ready);
	assign samples.ready = !valid_s1 || !out_valid_q || results.ready;
	assign accept        = samples.valid && samples.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_s1    <= samples.sample;
			chunk_end_s1 <= samples.chunk_end;
		end
	end

	// state update happens as the item leaves the input register
	nge_env_update #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.COEFF_BITS (COEFF_BITS)
	) u_env (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (adv),
		.sample       (sample_s1),
		.threshold    (threshold),
		.attack_coeff (attack_coeff),
		.release_coeff(release_coeff),
		.hold_samples (hold_samples),
		.env_next     (env_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			envelope_q    <= env_next;
			gate_closed_q <= env_next < nge_pkg::GAIN_HALF;
			gate_update_q <= chunk_end_s1;
		end
	end

	assign results.valid       = out_valid_q;
	assign results.envelope    = envelope_q;
	assign results.gate_closed = gate_closed_q;
	assign results.gate_update = gate_update_q;

	a_gate_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> gate_closed_q == (envelope_q < nge_pkg::GAIN_HALF))
		else $error("gate_closed disagrees with envelope");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1 && $stable(sample_s1) && $stable(chunk_end_s1))
		else $error("stalled input stage lost its item");

	a_adv_fills: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> out_valid_q)
		else $error("result register not filled");

endmodule
